[rtl/itp_pkg.sv]
// Shared package for the infix-to-postfix converter.
// Token kind codes, status codes, FSM state type, control/status structs
// and operator classification helpers. No dependencies.
package itp_pkg;

  typedef logic [4:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_NUM    = 5'd0;
  localparam kind_t KIND_VAR    = 5'd1;
  localparam kind_t KIND_ADD    = 5'd2;
  localparam kind_t KIND_SUB    = 5'd3;
  localparam kind_t KIND_MUL    = 5'd4;
  localparam kind_t KIND_DIV    = 5'd5;
  localparam kind_t KIND_POW    = 5'd6;
  localparam kind_t KIND_NEG    = 5'd7;
  localparam kind_t KIND_LPAREN = 5'd8;
  localparam kind_t KIND_RPAREN = 5'd9;
  localparam kind_t KIND_COMMA  = 5'd10;
  localparam kind_t KIND_FUNC   = 5'd11;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_PAREN    = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOKEN,
    S_RFUNC,
    S_FLUSH,
    S_REPORT,
    S_FINISH
  } itp_state_t;

  typedef struct packed {
    logic accept;
    logic emit_tok;
    logic pop_emit;
    logic pop_drop;
    logic push;
    logic set_err_paren;
    logic set_err_ovf;
    logic note_prev;
    logic emit_report;
    logic finish;
    logic clear;
  } itp_cmd_t;

  typedef struct packed {
    kind_t tok_kind;
    logic  tok_last;
    logic  err_set;
    logic  empty;
    logic  full;
    kind_t top_kind;
    logic  emit_ok;
    logic  pend_valid;
    logic  out_free;
  } itp_stat_t;

  function automatic logic is_operand(input kind_t k);
    return (k == KIND_NUM) || (k == KIND_VAR);
  endfunction

  function automatic logic is_op(input kind_t k);
    return (k >= KIND_ADD) && (k <= KIND_NEG);
  endfunction

  function automatic logic is_func(input kind_t k);
    return k >= KIND_FUNC;
  endfunction

  function automatic logic right_assoc(input kind_t k);
    return (k == KIND_POW) || (k == KIND_NEG);
  endfunction

  function automatic logic [2:0] prec(input kind_t k);
    logic [2:0] p;
    p = 3'd0;
    if (k == KIND_ADD || k == KIND_SUB) p = 3'd1;
    else if (k == KIND_MUL || k == KIND_DIV) p = 3'd2;
    else if (k == KIND_POW) p = 3'd3;
    else if (k == KIND_NEG) p = 3'd4;
    return p;
  endfunction

endpackage

[rtl/itp_token_if.sv]
// Token input channel: valid/ready handshake with the classified token.
// Depends on nothing.
interface itp_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [63:0] token_payload;
  logic        expr_end;

  modport source (output valid, token_kind, token_payload, expr_end, input ready);
  modport sink   (input valid, token_kind, token_payload, expr_end, output ready);
endinterface

[rtl/itp_result_if.sv]
// Result output channel: valid/ready handshake with one postfix result.
// Depends on nothing.
interface itp_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_kind;
  logic [63:0] out_payload;
  logic        is_end_report;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, out_kind, out_payload, is_end_report, status, last_of_run,
                  input ready);
  modport sink   (input valid, out_kind, out_payload, is_end_report, status, last_of_run,
                  output ready);
endinterface

[rtl/infix_to_postfix_converter.sv]
// Infix-to-postfix converter (shunting-yard) top level.
// Each token is accepted, then pops stack entries as needed before its push or emit; the RFUNC
// step pops a function under a closing paren. The final token flushes the stack (an open paren
// left sets the paren error) and emits the end report; output stalls hold each step.
// Synchronous active-high reset empties the stack and clears state; no clearing pass.
// Uses itp_pkg, itp_token_if, itp_result_if, itp_ctrl and itp_datapath.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input logic         clk,
  input logic         rst,
  itp_token_if.sink   tokens,
  itp_result_if.source results
);

  itp_cmd_t  cmd;
  itp_stat_t stat;
  logic      in_ready;

  assign tokens.ready = in_ready;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tokens.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .token_kind    (tokens.token_kind),
    .token_payload (tokens.token_payload),
    .expr_end      (tokens.expr_end),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_kind      (results.out_kind),
    .out_payload   (results.out_payload),
    .out_end       (results.is_end_report),
    .out_status    (results.status),
    .out_last      (results.last_of_run)
  );

endmodule

[rtl/itp_ctrl.sv]
// Controller FSM of the infix-to-postfix converter.
// Sequences accept, pop, push, flush and report steps; uses itp_pkg.
module itp_ctrl
  import itp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  itp_stat_t stat,
  output itp_cmd_t  cmd
);

  itp_state_t state;
  itp_state_t state_next;
  itp_state_t done_state;
  logic       top_open;
  logic       op_pops;
  logic       func_pops;
  kind_t      kind;
  kind_t      top;

  assign kind       = stat.tok_kind;
  assign top        = stat.top_kind;
  assign top_open   = !stat.empty && (top != KIND_LPAREN);
  assign func_pops  = !stat.empty && is_func(top);
  assign op_pops    = !stat.empty && is_op(top) &&
                      (right_assoc(kind) ? (prec(kind) < prec(top)) : (prec(kind) <= prec(top)));
  assign done_state = stat.tok_last ? S_FLUSH : S_FINISH;
  assign in_ready   = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_TOKEN;
      end
      S_TOKEN: begin
        priority if (stat.err_set) begin
          state_next = done_state;
        end else if (is_operand(kind)) begin
          if (stat.emit_ok) state_next = done_state;
        end else if (is_func(kind) || kind == KIND_LPAREN) begin
          state_next = done_state;
        end else if (kind == KIND_COMMA) begin
          if (!top_open) state_next = done_state;
        end else if (is_op(kind)) begin
          if (!op_pops) state_next = done_state;
        end else begin
          if (top_open) state_next = state;
          else if (stat.empty) state_next = done_state;
          else state_next = S_RFUNC;
        end
      end
      S_RFUNC: begin
        if (!func_pops || stat.emit_ok) state_next = done_state;
      end
      S_FLUSH: begin
        if (stat.err_set || stat.empty) state_next = S_REPORT;
      end
      S_REPORT: begin
        if (stat.emit_ok) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.pend_valid || stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_TOKEN: begin
        priority if (stat.err_set) begin
          cmd = '0;
        end else if (is_operand(kind)) begin
          if (stat.emit_ok) begin
            cmd.emit_tok  = 1'b1;
            cmd.note_prev = 1'b1;
          end
        end else if (is_func(kind) || kind == KIND_LPAREN) begin
          cmd.set_err_ovf = stat.full;
          cmd.push        = !stat.full;
          cmd.note_prev   = 1'b1;
        end else if (kind == KIND_COMMA) begin
          if (top_open) cmd.pop_emit = stat.emit_ok;
          else cmd.note_prev = 1'b1;
        end else if (is_op(kind)) begin
          if (op_pops) begin
            cmd.pop_emit = stat.emit_ok;
          end else begin
            cmd.set_err_ovf = stat.full;
            cmd.push        = !stat.full;
            cmd.note_prev   = 1'b1;
          end
        end else begin
          if (top_open) begin
            cmd.pop_emit = stat.emit_ok;
          end else if (stat.empty) begin
            cmd.set_err_paren = 1'b1;
            cmd.note_prev     = 1'b1;
          end else begin
            cmd.pop_drop = 1'b1;
          end
        end
      end
      S_RFUNC: begin
        if (func_pops) begin
          cmd.pop_emit  = stat.emit_ok;
          cmd.note_prev = stat.emit_ok;
        end else begin
          cmd.note_prev = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!stat.err_set && !stat.empty) begin
          if (top == KIND_LPAREN) cmd.set_err_paren = 1'b1;
          else cmd.pop_emit = stat.emit_ok;
        end
      end
      S_REPORT: begin
        cmd.emit_report = stat.emit_ok;
        cmd.clear       = stat.emit_ok;
      end
      S_FINISH: begin
        cmd.finish = stat.pend_valid && stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/itp_datapath.sv]
// Datapath of the infix-to-postfix converter: token register, operator
// stack memory with registered top, expression state, result staging and
// output register. Uses itp_pkg.
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  itp_cmd_t    cmd,
  output itp_stat_t   stat,
  input  logic [4:0]  token_kind,
  input  logic [63:0] token_payload,
  input  logic        expr_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_kind,
  output logic [63:0] out_payload,
  output logic        out_end,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  kind_t       tok_kind;
  logic [63:0] tok_payload;
  logic        tok_last;
  kind_t       kind_conv;

  kind_t       stack_mem [STACK_DEPTH];
  kind_t       top_kind;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] rd_addr;

  kind_t       prev_kind;
  logic        at_start;
  status_t     err_code;

  logic        pend_valid;
  kind_t       pend_kind;
  logic [63:0] pend_payload;
  logic        pend_end;
  status_t     pend_status;

  logic        emit;
  kind_t       emit_kind;
  logic [63:0] emit_payload;
  logic        out_free;
  logic        emit_ok;

  // sub becomes negation at start or after lparen, operator or comma
  always_comb begin
    kind_conv = token_kind;
    if (token_kind == KIND_SUB &&
        (at_start || prev_kind == KIND_LPAREN || is_op(prev_kind) || prev_kind == KIND_COMMA))
      kind_conv = KIND_NEG;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tok_kind    <= kind_conv;
      tok_payload <= token_payload;
      tok_last    <= expr_end;
    end
  end

  always_comb begin
    priority if (cmd.clear) count_next = '0;
    else if (cmd.push) count_next = count + CW'(1);
    else if (cmd.pop_emit || cmd.pop_drop) count_next = count - CW'(1);
    else count_next = count;
  end

  assign count_dec = count_next - CW'(1);
  assign rd_addr   = count_dec[AW-1:0];

  // top register always mirrors the entry below count_next
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count[AW-1:0]] <= tok_kind;
    end
    if (cmd.push) begin
      top_kind <= tok_kind;
    end else begin
      top_kind <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_kind <= KIND_NUM;
      at_start  <= 1'b1;
      err_code  <= STATUS_OK;
    end else begin
      count <= count_next;
      if (cmd.clear) begin
        prev_kind <= KIND_NUM;
        at_start  <= 1'b1;
        err_code  <= STATUS_OK;
      end else begin
        if (cmd.note_prev) begin
          prev_kind <= tok_kind;
          at_start  <= 1'b0;
        end
        if (cmd.set_err_paren) err_code <= STATUS_PAREN;
        else if (cmd.set_err_ovf) err_code <= STATUS_OVERFLOW;
      end
    end
  end

  assign emit         = cmd.emit_tok || cmd.pop_emit || cmd.emit_report;
  assign emit_kind    = cmd.emit_tok ? tok_kind : (cmd.pop_emit ? top_kind : KIND_NUM);
  assign emit_payload = cmd.emit_tok ? tok_payload : 64'd0;
  assign out_free     = !out_valid || out_ready;
  assign emit_ok      = !pend_valid || out_free;

  // staged result: last_of_run is known only when the next one arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) pend_valid <= 1'b1;
      else if (cmd.finish) pend_valid <= 1'b0;
      if ((emit && pend_valid) || cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_kind    <= emit_kind;
      pend_payload <= emit_payload;
      pend_end     <= cmd.emit_report;
      pend_status  <= cmd.emit_report ? err_code : STATUS_OK;
    end
    if ((emit && pend_valid) || cmd.finish) begin
      out_kind    <= pend_kind;
      out_payload <= pend_payload;
      out_end     <= pend_end;
      out_status  <= pend_status;
      out_last    <= cmd.finish;
    end
  end

  assign stat.tok_kind   = tok_kind;
  assign stat.tok_last   = tok_last;
  assign stat.err_set    = (err_code != STATUS_OK);
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CW'(STACK_DEPTH));
  assign stat.top_kind   = top_kind;
  assign stat.emit_ok    = emit_ok;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

endmodule
